// ===== hdl/lmt_pkg.sv =====
package lmt_pkg;

    localparam int RAW_W     = 24;
    localparam int UV_W      = 16;
    localparam int MAG_W     = 19;   // magnitude bits [23:5], low five cleared
    localparam int SCALE_W   = 32;
    localparam int PROD_W    = MAG_W + SCALE_W;
    localparam int SCALE_SH  = 35;   // 40-bit fraction less the five cleared bits
    localparam int RETRY_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // floor(2^40 * 2.445e6 / (128 * 8388607))
    localparam logic [SCALE_W-1:0] UV_SCALE_Q40 = 32'd2503680298;

    localparam logic [RAW_W-1:0] FAIL_WORD    = 24'h7FFFFF;
    localparam logic [RAW_W-1:0] TIMEOUT_WORD = 24'hFFFFFF;

    localparam logic [4:0] MIN_ONES = 5'd3;
    localparam logic [4:0] MAX_ONES = 5'd21;

    localparam logic signed [UV_W-1:0] MIN_MEDIAN_UV = 16'sd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_ZERO_OFFSET = 2'd1,
        REG_HIT_LOW     = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MULT,
        ST_WRITE,
        ST_SEARCH,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic load_in;
        logic check;
        logic mult;
        logic write_win;
        logic search;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic emit;
        logic rank_hit;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/lmt_if.sv =====
interface lmt_sample_if;
    logic                       valid;
    logic                       ready;
    logic [lmt_pkg::RAW_W-1:0]  raw_bits;
    logic                       timed_out;
    logic                       resync;

    modport source (output valid, output raw_bits, output timed_out, output resync,
                    input ready);
    modport sink   (input valid, input raw_bits, input timed_out, input resync,
                    output ready);
endinterface

interface lmt_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [lmt_pkg::UV_W-1:0]   median_uv;
    logic                              trigger_level;
    logic                              level_updated;

    modport source (output valid, output median_uv, output trigger_level,
                    output level_updated, input ready);
    modport sink   (input valid, input median_uv, input trigger_level,
                    input level_updated, output ready);
endinterface

interface lmt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lmt_pkg::CFG_IDX_W-1:0]       index;
    logic [lmt_pkg::CFG_DAT_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lmt_ctrl.sv =====
module lmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lmt_pkg::t_status i_status,
    output lmt_pkg::t_cmd    o_cmd
);

    lmt_pkg::t_state r_state;
    lmt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lmt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = lmt_pkg::ST_CHECK;
                end
            end
            lmt_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.reject ? lmt_pkg::ST_IDLE : lmt_pkg::ST_MULT;
            end
            lmt_pkg::ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = lmt_pkg::ST_WRITE;
            end
            lmt_pkg::ST_WRITE: begin
                o_cmd.write_win = 1'b1;
                n_state         = i_status.emit ? lmt_pkg::ST_SEARCH : lmt_pkg::ST_IDLE;
            end
            lmt_pkg::ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.rank_hit) begin
                    n_state = lmt_pkg::ST_EVAL;
                end
            end
            lmt_pkg::ST_EVAL: begin
                // hold here until the output register can take the transaction
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = lmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lmt_datapath.sv =====
module lmt_datapath #(
    parameter int WINDOW_SIZE = 5,
    parameter int TRY_LIMIT   = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lmt_pkg::t_cmd                          i_cmd,
    output lmt_pkg::t_status                       o_status,
    input  logic [lmt_pkg::RAW_W-1:0]              i_raw_bits,
    input  logic                                   i_timed_out,
    input  logic                                   i_resync,
    input  logic                                   i_cfg_we,
    input  logic [lmt_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [lmt_pkg::CFG_DAT_W-1:0]          i_cfg_data,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [lmt_pkg::UV_W-1:0]        o_median_uv,
    output logic                                   o_trigger_level,
    output logic                                   o_level_updated
);

    localparam int SLOT_W = $clog2(WINDOW_SIZE);
    localparam int RANK_W = $clog2(WINDOW_SIZE + 1);
    localparam int MID    = WINDOW_SIZE / 2;

    // configuration
    logic [15:0]        r_threshold;
    logic signed [15:0] r_zero_offset;
    logic               r_hit_low;

    // captured attempt
    logic [lmt_pkg::RAW_W-1:0] r_raw;
    logic                      r_timed_out;

    logic [lmt_pkg::RETRY_W-1:0] r_retry;
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_full;
    logic                        r_trig;

    logic [lmt_pkg::MAG_W-1:0]   r_mag;
    logic                        r_neg;
    logic [lmt_pkg::UV_W-1:0]    r_uv_mag;
    logic                        r_uv_neg;

    logic signed [lmt_pkg::UV_W-1:0] r_window [WINDOW_SIZE];
    logic [SLOT_W-1:0]               r_k;
    logic signed [lmt_pkg::UV_W-1:0] r_median;

    logic                            r_out_valid;
    logic signed [lmt_pkg::UV_W-1:0] r_out_median;
    logic                            r_out_trig;
    logic                            r_out_upd;

    // ---- popcount check and word selection
    logic [4:0]                ones;
    logic                      good;
    logic                      last_try;
    logic [lmt_pkg::RAW_W-1:0] word;
    logic [lmt_pkg::RAW_W-1:0] word_neg;

    always_comb begin
        ones     = 5'($countones(r_raw));
        good     = (ones >= lmt_pkg::MIN_ONES) && (ones <= lmt_pkg::MAX_ONES);
        last_try = ({1'b0, r_retry} + 3'd1) >= 3'(TRY_LIMIT);
        if (r_timed_out) begin
            word = lmt_pkg::TIMEOUT_WORD;
        end else if (good) begin
            word = r_raw;
        end else begin
            word = lmt_pkg::FAIL_WORD;
        end
        word_neg = ~word + 24'd1;
    end

    // ---- scaling
    logic [lmt_pkg::PROD_W-1:0] product;
    assign product = {{lmt_pkg::SCALE_W{1'b0}}, r_mag} * lmt_pkg::PROD_W'(lmt_pkg::UV_SCALE_Q40);

    logic signed [lmt_pkg::UV_W-1:0] uv_val;
    assign uv_val = r_uv_neg ? -$signed(r_uv_mag) : $signed(r_uv_mag);

    logic last_slot;
    assign last_slot = (r_slot == SLOT_W'(WINDOW_SIZE - 1));

    // ---- rank of one candidate against the whole window
    logic signed [lmt_pkg::UV_W-1:0] cand;
    logic [WINDOW_SIZE-1:0]          below;
    logic [RANK_W-1:0]               rank;
    logic                            rank_hit;

    always_comb begin
        cand = r_window[r_k];
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            // ties broken by slot index so exactly one entry has each rank
            below[j] = (r_window[j] < cand) ||
                       ((r_window[j] == cand) && (SLOT_W'(j) < r_k));
        end
        rank     = RANK_W'($countones(below));
        rank_hit = (rank == RANK_W'(MID));
    end

    // ---- trigger evaluation
    logic signed [16:0] diff;
    logic [16:0]        diff_abs;
    logic               big;
    logic               triggered;
    logic               n_trig;

    always_comb begin
        big       = (r_median >= lmt_pkg::MIN_MEDIAN_UV) ||
                    (r_median <= -lmt_pkg::MIN_MEDIAN_UV);
        diff      = {r_median[15], r_median} - {r_zero_offset[15], r_zero_offset};
        diff_abs  = diff[16] ? 17'(-diff) : 17'(diff);
        triggered = diff_abs >= {1'b0, r_threshold};
        n_trig    = big ? (triggered ^ r_hit_low) : r_trig;
    end

    assign o_status.reject   = !r_timed_out && !good && !last_try;
    assign o_status.emit     = r_full || last_slot;
    assign o_status.rank_hit = rank_hit;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_zero_offset <= '0;
            r_hit_low     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lmt_pkg::REG_THRESHOLD:   r_threshold   <= i_cfg_data;
                lmt_pkg::REG_ZERO_OFFSET: r_zero_offset <= $signed(i_cfg_data);
                lmt_pkg::REG_HIT_LOW:     r_hit_low     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry     <= '0;
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_trig      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in && i_resync) begin
                r_retry <= '0;
                r_slot  <= '0;
                r_full  <= 1'b0;
            end
            if (i_cmd.check) begin
                if (o_status.reject) begin
                    r_retry <= r_retry + 2'd1;
                end else begin
                    r_retry <= '0;
                end
            end
            if (i_cmd.write_win) begin
                if (last_slot) begin
                    r_slot <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_trig      <= n_trig;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw       <= i_raw_bits;
            r_timed_out <= i_timed_out;
        end
        if (i_cmd.check) begin
            r_neg <= word[23];
            r_mag <= word[23] ? word_neg[23:5] : word[23:5];
        end
        if (i_cmd.mult) begin
            r_uv_mag <= product[lmt_pkg::SCALE_SH +: lmt_pkg::UV_W];
            r_uv_neg <= r_neg;
        end
        if (i_cmd.write_win) begin
            r_window[r_slot] <= uv_val;
            r_k              <= '0;
        end
        if (i_cmd.search) begin
            if (rank_hit) begin
                r_median <= cand;
            end else begin
                r_k <= r_k + SLOT_W'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_median <= r_median;
            r_out_trig   <= n_trig;
            r_out_upd    <= big;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_median_uv     = r_out_median;
    assign o_trigger_level = r_out_trig;
    assign o_level_updated = r_out_upd;

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < (SLOT_W + 1)'(WINDOW_SIZE))
        else $error("write slot out of range");

    a_retry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_retry} < 3'(TRY_LIMIT))
        else $error("retry count reached the limit");

    a_search_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.search && (r_k == SLOT_W'(WINDOW_SIZE - 1))) |-> rank_hit)
        else $error("rank search ran past the window");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending transaction");

    a_search_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search |-> r_full)
        else $error("median formed before the window was filled");
`endif

endmodule

// ===== hdl/loadcell_median_trigger.sv =====
// Load-cell median trigger. Each input transaction is one 24-bit converter read
// attempt; a read with fewer than 3 or more than 21 ones is retried, and after
// TRY_LIMIT bad reads 0x7FFFFF is used, while a timeout counts as all ones. The
// value is scaled to microvolts, written into a WINDOW_SIZE-entry ring, and once
// the ring has been filled since the last resync every value yields one result:
// the window median (the upper middle entry for even sizes) and the trigger
// level, which is re-evaluated only when |median| >= 20 uV. One attempt is
// worked at a time. A rejected read passes only the check state, a read that only
// fills the window passes check, multiply and window write, and a read that gives
// a result then also runs the rank search, testing one window entry per cycle
// against all others, and the evaluation; a result also waits while the output
// register still holds an untaken transaction. Configuration writes are taken
// at any time with ready held high and must come only while the block is idle.
module loadcell_median_trigger #(
    parameter int WINDOW_SIZE = 5,
    parameter int TRY_LIMIT   = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lmt_sample_if.sink   i_sample,
    lmt_result_if.source o_result,
    lmt_cfg_if.sink      i_cfg
);

    lmt_pkg::t_cmd    cmd;
    lmt_pkg::t_status status;
    logic             in_ready;

    assign i_sample.ready = in_ready;
    assign i_cfg.ready    = 1'b1;

    lmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lmt_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .TRY_LIMIT   (TRY_LIMIT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_raw_bits      (i_sample.raw_bits),
        .i_timed_out     (i_sample.timed_out),
        .i_resync        (i_sample.resync),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_median_uv     (o_result.median_uv),
        .o_trigger_level (o_result.trigger_level),
        .o_level_updated (o_result.level_updated)
    );

endmodule
